### hw/rtl/dimdct_pkg.sv
// package for the direct-form inverse mdct block
// holds sizes, the cosine rom built at elaboration, the fsm type and
// the command and status structs; depends on nothing
`default_nettype none

package dimdct_pkg;

  // transform size and field widths
  localparam int BLOCK_N  = 32;
  localparam int COEF_W   = 20;
  localparam int COS_W    = 16;
  localparam int SAMPLE_W = 26;
  localparam int FRAC_W   = 15;
  localparam int PROD_W   = COEF_W + COS_W;
  // one guard bit over the rounded sample range covers the sum of N terms
  localparam int ACC_W    = SAMPLE_W + FRAC_W + 1;
  // rounded sum before saturation
  localparam int RND_W    = ACC_W - FRAC_W;
  localparam int K_W      = $clog2(BLOCK_N);
  localparam int N_W      = $clog2(2 * BLOCK_N);
  localparam int ROM_SIZE = 8 * BLOCK_N;
  localparam int QUARTER  = 2 * BLOCK_N;
  localparam int ROM_AW   = $clog2(ROM_SIZE);

  localparam logic [K_W-1:0] K_LAST = K_W'(BLOCK_N - 1);
  localparam logic [N_W-1:0] N_LAST = N_W'(2 * BLOCK_N - 1);

  // rom index of term k=0 for sample n=0, and its step over k
  localparam logic [ROM_AW-1:0] BASE_INIT   = ROM_AW'((1 + BLOCK_N) % ROM_SIZE);
  localparam logic [ROM_AW-1:0] STRIDE_INIT = ROM_AW'((2 + 2 * BLOCK_N) % ROM_SIZE);

  // taylor series constants, q30
  localparam longint unsigned TWO_PI_Q30 = 64'd6746518852;
  localparam longint unsigned ONE_Q30    = 64'd1073741824;
  localparam longint unsigned TAYLOR_DIV [1:8] = '{2, 12, 30, 56, 90, 132, 182, 240};

  typedef enum logic {
    ST_LOAD,
    ST_CALC
  } state_e;

  // controller to datapath, one step per cycle unless the datapath stalls
  typedef struct packed {
    logic              wr_en;
    logic [K_W-1:0]    wr_addr;
    logic              issue;
    logic [K_W-1:0]    rd_addr;
    logic [ROM_AW-1:0] rom_idx;
    logic              first_term;
    logic              last_term;
    logic              last_sample;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic stall;
  } dp_status_t;

  typedef logic signed [COS_W-1:0] cos_rom_t [ROM_SIZE];

  // q15 cosine of 2*pi*j/ROM_SIZE over the first quadrant
  function automatic logic [COS_W-1:0] quarter_cos(input int unsigned j);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned mag;
    longint          sum;
    longint          r;
    x   = (TWO_PI_Q30 * 64'(j) + 64'(ROM_SIZE / 2)) / ROM_SIZE;
    x2  = (x * x) >> 30;
    mag = ONE_Q30;
    sum = longint'(ONE_Q30);
    for (int t = 1; t <= 8; t++) begin
      mag = (mag * x2) >> 30;
      mag = mag / TAYLOR_DIV[t];
      if (t % 2 == 1) begin
        sum = sum - longint'(mag);
      end else begin
        sum = sum + longint'(mag);
      end
    end
    if (sum < 0) begin
      sum = 0;
    end
    if (sum > longint'(ONE_Q30)) begin
      sum = longint'(ONE_Q30);
    end
    r = (sum + 16384) >>> 15;
    if (r > 32767) begin
      r = 32767;
    end
    return r[COS_W-1:0];
  endfunction

  // full-wave table mirrored from the first quadrant
  function automatic cos_rom_t build_cos_rom();
    cos_rom_t rom;
    for (int i = 0; i < ROM_SIZE; i++) begin
      if (i <= QUARTER) begin
        rom[i] = $signed(quarter_cos(i));
      end else if (i <= 2 * QUARTER) begin
        rom[i] = -$signed(quarter_cos(2 * QUARTER - i));
      end else if (i <= 3 * QUARTER) begin
        rom[i] = -$signed(quarter_cos(i - 2 * QUARTER));
      end else begin
        rom[i] = $signed(quarter_cos(4 * QUARTER - i));
      end
    end
    return rom;
  endfunction

  localparam cos_rom_t COS_ROM = build_cos_rom();

  // a + b modulo ROM_SIZE, both operands already below ROM_SIZE
  function automatic logic [ROM_AW-1:0] rom_add(input logic [ROM_AW-1:0] a,
                                                input logic [ROM_AW-1:0] b);
    logic [ROM_AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (ROM_AW+1)'(ROM_SIZE)) begin
      s = s - (ROM_AW+1)'(ROM_SIZE);
    end
    return s[ROM_AW-1:0];
  endfunction

endpackage

`default_nettype wire

### hw/rtl/dimdct_ctrl.sv
// controller: load counter, term and sample counters, rom index walk
// uses dimdct_pkg; drives dimdct_dp through dp_cmd_t
`default_nettype none

module dimdct_ctrl (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  coefficient_valid_i,
  input  wire logic                  last_coefficient_i,
  output logic                       coefficient_ready_o,
  input  wire dimdct_pkg::dp_status_t status_i,
  output dimdct_pkg::dp_cmd_t        cmd_o
);

  dimdct_pkg::state_e                 state_q, state_d;
  logic [dimdct_pkg::K_W-1:0]         load_q, load_d;
  logic [dimdct_pkg::K_W-1:0]         k_q, k_d;
  logic [dimdct_pkg::N_W-1:0]         n_q, n_d;
  logic [dimdct_pkg::ROM_AW-1:0]      base_q, base_d;
  logic [dimdct_pkg::ROM_AW-1:0]      stride_q, stride_d;
  logic [dimdct_pkg::ROM_AW-1:0]      idx_q, idx_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dimdct_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_q   <= '0;
      k_q      <= '0;
      n_q      <= '0;
      base_q   <= dimdct_pkg::BASE_INIT;
      stride_q <= dimdct_pkg::STRIDE_INIT;
      idx_q    <= dimdct_pkg::BASE_INIT;
    end else begin
      load_q   <= load_d;
      k_q      <= k_d;
      n_q      <= n_d;
      base_q   <= base_d;
      stride_q <= stride_d;
      idx_q    <= idx_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d  = state_q;
    load_d   = load_q;
    k_d      = k_q;
    n_d      = n_q;
    base_d   = base_q;
    stride_d = stride_q;
    idx_d    = idx_q;

    coefficient_ready_o = 1'b0;
    cmd_o             = '0;
    cmd_o.wr_addr     = load_q;
    cmd_o.rd_addr     = k_q;
    cmd_o.rom_idx     = idx_q;
    cmd_o.first_term  = (k_q == '0);
    cmd_o.last_term   = (k_q == dimdct_pkg::K_LAST);
    cmd_o.last_sample = (k_q == dimdct_pkg::K_LAST) && (n_q == dimdct_pkg::N_LAST);

    case (state_q)
      dimdct_pkg::ST_LOAD: begin
        coefficient_ready_o = 1'b1;
        if (coefficient_valid_i) begin
          cmd_o.wr_en = 1'b1;
          if (last_coefficient_i) begin
            // flagged word: start the transform from sample 0
            load_d   = '0;
            k_d      = '0;
            n_d      = '0;
            base_d   = dimdct_pkg::BASE_INIT;
            stride_d = dimdct_pkg::STRIDE_INIT;
            idx_d    = dimdct_pkg::BASE_INIT;
            state_d  = dimdct_pkg::ST_CALC;
          end else if (load_q == dimdct_pkg::K_LAST) begin
            load_d = '0;
          end else begin
            load_d = load_q + 1'b1;
          end
        end
      end
      dimdct_pkg::ST_CALC: begin
        cmd_o.issue = 1'b1;
        if (!status_i.stall) begin
          if (k_q == dimdct_pkg::K_LAST) begin
            k_d = '0;
            if (n_q == dimdct_pkg::N_LAST) begin
              state_d = dimdct_pkg::ST_LOAD;
            end else begin
              // next sample: base moves by 2, stride by 4
              n_d      = n_q + 1'b1;
              base_d   = dimdct_pkg::rom_add(base_q, dimdct_pkg::ROM_AW'(2));
              stride_d = dimdct_pkg::rom_add(stride_q, dimdct_pkg::ROM_AW'(4));
              idx_d    = dimdct_pkg::rom_add(base_q, dimdct_pkg::ROM_AW'(2));
            end
          end else begin
            k_d   = k_q + 1'b1;
            idx_d = dimdct_pkg::rom_add(idx_q, stride_q);
          end
        end
      end
      default: begin
        state_d = dimdct_pkg::ST_LOAD;
      end
    endcase
  end

endmodule

`default_nettype wire

### hw/rtl/dimdct_dp.sv
// datapath: coefficient memory, cosine rom read, multiplier, accumulator,
// rounding and saturation, output register; uses dimdct_pkg
`default_nettype none

module dimdct_dp (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire dimdct_pkg::dp_cmd_t                 cmd_i,
  input  wire logic signed [dimdct_pkg::COEF_W-1:0] coefficient_i,
  input  wire logic                                sample_ready_i,
  output dimdct_pkg::dp_status_t                   status_o,
  output logic signed [dimdct_pkg::SAMPLE_W-1:0]   sample_o,
  output logic                                     sample_valid_o,
  output logic                                     last_sample_o
);

  logic signed [dimdct_pkg::COEF_W-1:0] coef_mem [dimdct_pkg::BLOCK_N];

  logic                                  s1_valid_q, s1_first_q, s1_last_q, s1_lsmp_q;
  logic signed [dimdct_pkg::COEF_W-1:0]  coef_q;
  logic signed [dimdct_pkg::COS_W-1:0]   cos_q;
  logic                                  s2_valid_q, s2_first_q, s2_last_q, s2_lsmp_q;
  logic signed [dimdct_pkg::PROD_W-1:0]  prod_q;
  logic signed [dimdct_pkg::ACC_W-1:0]   acc_q;
  logic                                  fin_q, fin_last_q;
  logic                                  out_valid_q, out_last_q;
  logic signed [dimdct_pkg::SAMPLE_W-1:0] out_q;

  logic                                  stall;
  logic                                  advance;
  logic                                  load_out;
  logic signed [dimdct_pkg::ACC_W-1:0]   rnd_sum;
  logic signed [dimdct_pkg::RND_W-1:0]   rnd;
  logic signed [dimdct_pkg::SAMPLE_W-1:0] sat;

  // finished sum waiting on a full output register freezes the pipe
  assign stall      = fin_q && out_valid_q && !sample_ready_i;
  assign advance    = !stall;
  assign load_out   = fin_q && !stall;
  assign status_o.stall = stall;

  // coefficient store write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      coef_mem[cmd_i.wr_addr] <= coefficient_i;
    end
  end

  // operand fetch, product and accumulator payload
  always_ff @(posedge clk_i) begin
    if (advance) begin
      if (cmd_i.issue) begin
        coef_q <= coef_mem[cmd_i.rd_addr];
        cos_q  <= dimdct_pkg::COS_ROM[cmd_i.rom_idx];
      end
      prod_q <= coef_q * cos_q;
      if (s2_valid_q) begin
        if (s2_first_q) begin
          acc_q <= dimdct_pkg::ACC_W'(prod_q);
        end else begin
          acc_q <= acc_q + dimdct_pkg::ACC_W'(prod_q);
        end
      end
    end
  end

  // pipeline tags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_first_q <= 1'b0;
      s1_last_q  <= 1'b0;
      s1_lsmp_q  <= 1'b0;
      s2_valid_q <= 1'b0;
      s2_first_q <= 1'b0;
      s2_last_q  <= 1'b0;
      s2_lsmp_q  <= 1'b0;
      fin_q      <= 1'b0;
      fin_last_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q <= cmd_i.issue;
      s1_first_q <= cmd_i.first_term;
      s1_last_q  <= cmd_i.last_term;
      s1_lsmp_q  <= cmd_i.last_sample;
      s2_valid_q <= s1_valid_q;
      s2_first_q <= s1_first_q;
      s2_last_q  <= s1_last_q;
      s2_lsmp_q  <= s1_lsmp_q;
      fin_q      <= s2_valid_q && s2_last_q;
      fin_last_q <= s2_lsmp_q;
    end
  end

  // round half up by 15 bits, then saturate
  always_comb begin
    rnd_sum = acc_q + dimdct_pkg::ACC_W'(1 << (dimdct_pkg::FRAC_W - 1));
    rnd     = rnd_sum[dimdct_pkg::ACC_W-1:dimdct_pkg::FRAC_W];
    if (rnd[dimdct_pkg::RND_W-1] != rnd[dimdct_pkg::RND_W-2]) begin
      sat = rnd[dimdct_pkg::RND_W-1] ? {1'b1, {(dimdct_pkg::SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(dimdct_pkg::SAMPLE_W-1){1'b1}}};
    end else begin
      sat = rnd[dimdct_pkg::SAMPLE_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
      out_last_q  <= fin_last_q;
    end else if (sample_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= sat;
    end
  end

  assign sample_o       = out_q;
  assign sample_valid_o = out_valid_q;
  assign last_sample_o  = out_last_q;

endmodule

`default_nettype wire

### hw/rtl/direct_imdct.sv
// top level of the direct-form inverse mdct
// instantiates dimdct_ctrl and dimdct_dp; uses dimdct_pkg
`default_nettype none

// Loads BLOCK_N coefficient words, one per cycle, into a small memory; the
// word flagged last_coefficient_i starts the transform and 2*BLOCK_N sample
// words follow in order, last_sample_o marking the final one. Every sample
// is a sum of BLOCK_N products on one shared multiply-accumulate unit, so
// that single MAC sets the throughput. No coefficient is taken while a
// transform runs. A finished sum that meets a held output sample stops the
// MAC pipe until that sample is taken. Without the flag, loading wraps to
// position 0 after BLOCK_N words and nothing is emitted; an early flag uses
// the store as it stands.
module direct_imdct (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 coefficient_valid_i,
  output logic                                      coefficient_ready_o,
  input  wire logic signed [dimdct_pkg::COEF_W-1:0] coefficient_i,
  input  wire logic                                 last_coefficient_i,
  output logic                                      sample_valid_o,
  input  wire logic                                 sample_ready_i,
  output logic signed [dimdct_pkg::SAMPLE_W-1:0]    sample_o,
  output logic                                      last_sample_o
);

  dimdct_pkg::dp_cmd_t    cmd;
  dimdct_pkg::dp_status_t status;

  // sequencer
  dimdct_ctrl u_ctrl (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .coefficient_valid_i (coefficient_valid_i),
    .last_coefficient_i  (last_coefficient_i),
    .coefficient_ready_o (coefficient_ready_o),
    .status_i            (status),
    .cmd_o               (cmd)
  );

  // mac datapath
  dimdct_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .coefficient_i  (coefficient_i),
    .sample_ready_i (sample_ready_i),
    .status_o       (status),
    .sample_o       (sample_o),
    .sample_valid_o (sample_valid_o),
    .last_sample_o  (last_sample_o)
  );

endmodule

`default_nettype wire

### tb/direct_imdct_test.sv
// self-checking testbench for direct_imdct, the direct-form inverse mdct
// depends on dimdct_pkg for sizes; predicts every sample word with its own cosine table
module direct_imdct_test;

  localparam int BLOCK_LEN    = dimdct_pkg::BLOCK_N;
  localparam int COEF_BITS    = dimdct_pkg::COEF_W;
  localparam int SAMPLE_BITS  = dimdct_pkg::SAMPLE_W;
  localparam int TABLE_LEN    = 8 * BLOCK_LEN;
  localparam int QUARTER_LEN  = 2 * BLOCK_LEN;
  localparam int SAMPLES      = 2 * BLOCK_LEN;
  localparam int RANDOM_WORDS = 340;
  // one full transform plus margin, to catch stray sample words at the end
  localparam int DRAIN_CYCLES = 2 * BLOCK_LEN * BLOCK_LEN + 100;
  // worst case: every word a block, each sample stalled by the longest receiver wait, taken several times over
  localparam int unsigned LIMIT_CYCLES = 12_000_000;

  localparam logic signed [COEF_BITS-1:0] COEF_MAX = COEF_BITS'((2 ** (COEF_BITS - 1)) - 1);
  localparam logic signed [COEF_BITS-1:0] COEF_MIN = COEF_BITS'(-(2 ** (COEF_BITS - 1)));
  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef enum logic {
    FILL_CONST,
    FILL_ALTERNATE
  } fill_e;

  typedef enum logic [1:0] {
    STYLE_FULL,
    STYLE_EXTREME,
    STYLE_SMALL
  } value_style_e;

  typedef struct packed {
    logic [6:0]                  words;
    fill_e                       fill;
    logic signed [COEF_BITS-1:0] value;
    logic                        flag_last;
    logic                        zero_typed;
  } stim_row_t;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] value;
    logic                          last;
  } sample_t;

  // directed blocks; the first one fills the whole store before any early flag
  localparam int DIRECTED_ROWS = 7;
  localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{7'd32, FILL_CONST,     '0,          1'b1, 1'b1},  // all zero, samples typed in
    '{7'd32, FILL_CONST,     COEF_MAX,    1'b1, 1'b0},  // full-scale positive
    '{7'd3,  FILL_CONST,     COEF_MIN,    1'b1, 1'b0},  // early flag over older store
    '{7'd1,  FILL_CONST,     20'sd1,      1'b1, 1'b0},  // value 1 in slot 0 over older store
    '{7'd34, FILL_ALTERNATE, COEF_MAX,    1'b1, 1'b0},  // missing flag wraps, then early flag
    '{7'd32, FILL_ALTERNATE, 20'sh55555,  1'b1, 1'b0},  // checkerboard bits
    '{7'd32, FILL_CONST,     '0,          1'b1, 1'b1}   // back to zero, samples typed in
  };

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          coefficient_valid_i = 1'b0;
  logic                          coefficient_ready_o;
  logic signed [COEF_BITS-1:0]   coefficient_i = '0;
  logic                          last_coefficient_i = 1'b0;
  logic                          sample_valid_o;
  logic                          sample_ready_i = 1'b0;
  logic signed [SAMPLE_BITS-1:0] sample_o;
  logic                          last_sample_o;

  int unsigned cycle_count = 0;
  int unsigned error_count = 0;
  bit          send_steady = 1'b0;
  bit          take_steady = 1'b0;

  // predictor state
  int                          cos_table [TABLE_LEN];
  logic signed [COEF_BITS-1:0] coef_store [BLOCK_LEN];
  int unsigned                 load_pos = 0;
  sample_t                     pending_samples [$];

  direct_imdct i_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .coefficient_valid_i (coefficient_valid_i),
    .coefficient_ready_o (coefficient_ready_o),
    .coefficient_i       (coefficient_i),
    .last_coefficient_i  (last_coefficient_i),
    .sample_valid_o      (sample_valid_o),
    .sample_ready_i      (sample_ready_i),
    .sample_o            (sample_o),
    .last_sample_o       (last_sample_o)
  );

  // clock and cycle count
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // q15 cosine of 2*pi*j/TABLE_LEN in the first quadrant, q30 taylor series through x^16
  function automatic int quarter_wave(input int unsigned j);
    longint unsigned angle;
    longint unsigned angle_sq;
    longint unsigned term;
    longint          series;
    longint          q15;
    angle    = (64'd6746518852 * 64'(j) + 64'(TABLE_LEN / 2)) / 64'(TABLE_LEN);
    angle_sq = (angle * angle) >> 30;
    term     = 64'd1 << 30;
    series   = longint'(1) <<< 30;
    for (int t = 1; t <= 8; t++) begin
      term = (term * angle_sq) >> 30;
      term = term / 64'((2 * t - 1) * (2 * t));
      if (t % 2 == 1) begin
        series = series - longint'(term);
      end else begin
        series = series + longint'(term);
      end
    end
    if (series < 0) begin
      series = 0;
    end
    if (series > (longint'(1) <<< 30)) begin
      series = longint'(1) <<< 30;
    end
    q15 = (series + 16384) >>> 15;
    if (q15 > 32767) begin
      q15 = 32767;
    end
    return int'(q15);
  endfunction

  // full-wave table mirrored with sign from the first quadrant
  task automatic build_cos_table();
    for (int i = 0; i < TABLE_LEN; i++) begin
      if (i <= QUARTER_LEN) begin
        cos_table[i] = quarter_wave(i);
      end else if (i <= 2 * QUARTER_LEN) begin
        cos_table[i] = -quarter_wave(2 * QUARTER_LEN - i);
      end else if (i <= 3 * QUARTER_LEN) begin
        cos_table[i] = -quarter_wave(i - 2 * QUARTER_LEN);
      end else begin
        cos_table[i] = quarter_wave(4 * QUARTER_LEN - i);
      end
    end
  endtask

  // store one accepted coefficient word; a flagged word queues the 2N samples it causes
  task automatic store_word(input logic signed [COEF_BITS-1:0] coef, input logic flag_last,
                            input logic zero_typed);
    longint  acc;
    longint  rounded;
    sample_t s;
    coef_store[load_pos] = coef;
    if (!flag_last) begin
      load_pos = (load_pos + 1 == BLOCK_LEN) ? 0 : load_pos + 1;
    end else begin
      load_pos = 0;
      for (int n = 0; n < SAMPLES; n++) begin
        acc = 0;
        for (int k = 0; k < BLOCK_LEN; k++) begin
          acc += longint'(coef_store[k]) *
                 longint'(cos_table[((2 * n + 1 + BLOCK_LEN) * (2 * k + 1)) % TABLE_LEN]);
        end
        // round half up, then saturate
        rounded = (acc + 16384) >>> 15;
        if (rounded > SAMPLE_HI) begin
          rounded = SAMPLE_HI;
        end
        if (rounded < SAMPLE_LO) begin
          rounded = SAMPLE_LO;
        end
        s.value = zero_typed ? '0 : rounded[SAMPLE_BITS-1:0];
        s.last  = (n == SAMPLES - 1);
        pending_samples.insert(pending_samples.size(), s);
      end
    end
  endtask

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // wait before a word, with occasional stretches of no waiting at all
  function automatic int unsigned draw_wait(inout bit steady);
    if ($urandom_range(0, 39) == 0) begin
      steady = !steady;
    end
    return steady ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic logic signed [COEF_BITS-1:0] draw_coef(input value_style_e style);
    case (style)
      STYLE_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return COEF_MAX;
          1: return COEF_MIN;
          2: return '0;
          3: return '1;
          default: return COEF_BITS'(1);
        endcase
      end
      STYLE_SMALL: begin
        return COEF_BITS'(int'($urandom_range(0, 4095)) - 2048);
      end
      default: begin
        return COEF_BITS'($urandom);
      end
    endcase
  endfunction

  // drive one coefficient word and hold it until taken
  task automatic send_word(input logic signed [COEF_BITS-1:0] coef, input logic flag_last,
                           input logic zero_typed);
    int unsigned idle;
    idle = draw_wait(send_steady);
    if (idle > 0) begin
      coefficient_valid_i <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    coefficient_valid_i <= 1'b1;
    coefficient_i       <= coef;
    last_coefficient_i  <= flag_last;
    do @(posedge clk_i); while (!coefficient_ready_o);
    store_word(coef, flag_last, zero_typed);
  endtask

  // stimulus and end of run
  initial begin
    stim_row_t                   row;
    int unsigned                 words_sent;
    int unsigned                 len;
    int unsigned                 pick;
    value_style_e                style;
    logic signed [COEF_BITS-1:0] coef;
    words_sent = 0;
    build_cos_table();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed blocks
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      for (int w = 0; w < row.words; w++) begin
        coef = (row.fill == FILL_ALTERNATE && w % 2 == 1) ? ~row.value : row.value;
        send_word(coef, row.flag_last && (w == row.words - 1), row.zero_typed);
      end
    end

    // random blocks: mostly full, some early flags, some wrapping without a flag
    while (words_sent < RANDOM_WORDS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        len = BLOCK_LEN;
      end else if (pick < 85) begin
        len = $urandom_range(1, BLOCK_LEN - 1);
      end else begin
        len = $urandom_range(BLOCK_LEN + 1, 2 * BLOCK_LEN - 4);
      end
      style = value_style_e'($urandom_range(0, 2));
      for (int w = 0; w < len; w++) begin
        send_word(draw_coef(style), w == len - 1, 1'b0);
        words_sent++;
      end
    end
    coefficient_valid_i <= 1'b0;

    while (pending_samples.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // sample receiver with random stalls, checks each word against the oldest prediction
  initial begin
    sample_t     want;
    int unsigned idle;
    int unsigned taken;
    taken = 0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      idle = draw_wait(take_steady);
      if (idle > 0) begin
        sample_ready_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
      sample_ready_i <= 1'b1;
      do @(posedge clk_i); while (!sample_valid_o);
      if (pending_samples.size() == 0) begin
        report_mismatch($sformatf("sample word %0d = %0d arrived with none expected",
                                  taken, sample_o));
      end else begin
        want = pending_samples.pop_front();
        if (sample_o !== want.value) begin
          report_mismatch($sformatf("sample word %0d: got %0d, expected %0d",
                                    taken, sample_o, want.value));
        end
        if (last_sample_o !== want.last) begin
          report_mismatch($sformatf("sample word %0d: last flag %b, expected %b",
                                    taken, last_sample_o, want.last));
        end
      end
      taken++;
    end
  end

  // timeout
  initial begin
    wait (cycle_count >= LIMIT_CYCLES);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
